// ----- hw/rtl/mef_pkg.sv -----
// Package for the majority element finder: item types, the tally control
// struct and the default store depth. It depends on nothing else.
`default_nettype none

package mef_pkg;

    localparam int MEF_MAX_ITEMS = 1024;
    localparam int MEF_DATA_W    = 32;

    typedef struct packed {
        logic signed [MEF_DATA_W-1:0] item_value;
        logic                         is_last;
    } t_in_item;

    typedef struct packed {
        logic                         found;
        logic signed [MEF_DATA_W-1:0] major_value;
    } t_out_item;

    typedef struct packed {
        logic vote;
        logic tally;
        logic clear;
    } t_tally_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/mef_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// It stands alone and uses no package.
`default_nettype none

module mef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/mef_tally.sv -----
// Shared compare unit of the majority element finder: one equality compare
// drives both the running vote and the occurrence count. Uses mef_pkg.
`default_nettype none

module mef_tally import mef_pkg::*; #(
    parameter int CW = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_tally_ctl            i_ctl,
    input  wire logic [MEF_DATA_W-1:0] i_data,
    output logic      [MEF_DATA_W-1:0] o_candidate,
    output logic      [CW-1:0]         o_hits
);

    logic [MEF_DATA_W-1:0] r_candidate, n_candidate;
    logic [CW-1:0]         r_votes, n_votes;
    logic [CW-1:0]         r_hits, n_hits;
    logic                  match;

    assign match = (i_data == r_candidate);

    always_comb begin
        n_candidate = r_candidate;
        n_votes     = r_votes;
        n_hits      = r_hits;
        if (i_ctl.clear) begin
            n_candidate = '0;
            n_votes     = '0;
            n_hits      = '0;
        end else begin
            if (i_ctl.vote) begin
                if (r_votes == '0) begin
                    n_candidate = i_data;
                    n_votes     = CW'(1);
                end else if (match) begin
                    n_votes = r_votes + CW'(1);
                end else begin
                    n_votes = r_votes - CW'(1);
                end
            end
            if (i_ctl.tally && match) begin
                n_hits = r_hits + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate <= '0;
            r_votes     <= '0;
            r_hits      <= '0;
        end else begin
            r_candidate <= n_candidate;
            r_votes     <= n_votes;
            r_hits      <= n_hits;
        end
    end

    assign o_candidate = r_candidate;
    assign o_hits      = r_hits;

endmodule

`default_nettype wire

// ----- hw/rtl/majority_element_finder_unit.sv -----
// Top level of the majority element finder: sequencer, list store and
// shared tally unit. Uses mef_pkg, mef_ram and mef_tally.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready| o_out_item (t_out_item)
//
// Items of a list are taken one per cycle while the input is ready; the N stored
// items of a list are then read back in a verification pass over the store's read port.
// The input is not ready during that pass, nor while a result is held
// waiting for an earlier one to be taken by the output.
// Reset is synchronous, active low, and clears the list and control state.
// Items beyond MAX_ITEMS are dropped, but a dropped last item ends the list.
`default_nettype none

module majority_element_finder_unit import mef_pkg::*; #(
    parameter int MAX_ITEMS = MEF_MAX_ITEMS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_rd_vld;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item, n_out_item;

    logic                  accept;
    logic                  full;
    logic                  store;
    logic                  result_free;
    logic                  found;
    logic [MEF_DATA_W-1:0] rdata;
    logic [MEF_DATA_W-1:0] candidate;
    logic [CW-1:0]         hits;
    t_tally_ctl            tally_ctl;

    assign o_in_ready  = (r_state == S_LOAD);
    assign accept      = i_in_valid && o_in_ready;
    assign full        = (r_count == CW'(MAX_ITEMS));
    assign store       = accept && !full;
    assign result_free = !r_out_valid || i_out_ready;
    assign found       = {hits, 1'b0} > {1'b0, r_count};

    assign tally_ctl = '{
        vote:  store,
        tally: r_rd_vld,
        clear: (r_state == S_DONE) && result_free
    };

    mef_ram #(
        .WIDTH (MEF_DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_item.item_value),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    mef_tally #(
        .CW (CW)
    ) u_tally (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tally_ctl),
        .i_data      (store ? i_in_item.item_value : rdata),
        .o_candidate (candidate),
        .o_hits      (hits)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                if (store) begin
                    n_count = r_count + CW'(1);
                end
                if (accept && i_in_item.is_last) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx = r_idx + CW'(1);
                if (r_idx == CW'(r_count - CW'(1))) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (result_free) begin
                    n_out_valid            = 1'b1;
                    n_out_item.found       = found;
                    n_out_item.major_value = found ? candidate : '0;
                    n_count                = '0;
                    n_state                = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_vld    <= (r_state == S_SCAN);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("stored item count exceeds the store depth");

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_count))
        else $error("verification read beyond the stored list");

    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hits <= r_count || r_state == S_LOAD)
        else $error("occurrence count exceeds the list length");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.major_value == '0))
        else $error("value reported without a majority");

    a_done_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && result_free) |=> (r_state == S_LOAD && o_out_valid))
        else $error("result not issued when the output was free");
`endif

endmodule

`default_nettype wire
